@@ src/dpdd_pkg.sv @@
// Package for the dense pool with deferred delete.
// Holds operation and status codes and the capacity constants shared by the pool files; depends on nothing.
package dpdd_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_DEL   = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_QUEUEFULL = 2'd3;

    localparam int unsigned CAP_W    = 7;
    localparam logic [6:0]  CAP_INIT = 7'd64;

endpackage

@@ src/dpdd_ram.sv @@
// Single-port-write, single-port-read synchronous memory with a registered read.
// Used by the pool top level for entries and delete marks; no dependencies.
module dpdd_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/dense_pool_deferred_delete_unit.sv @@
// Dense pool with deferred swap-remove deletion: top level.
// One item is taken at a time. A flush with nothing queued ends without a walk; else it
// walks the mark memory from the top slot down, reading each mark and then clearing it;
// a marked live slot drops the live count, and one below the last first gets the last
// entry, moved through the entry memory port. Reset: counters clear at once; a clearing
// pass then zeroes the marks, during which no item is taken.
// Depends on dpdd_pkg and dpdd_ram.
module dense_pool_deferred_delete_unit #(
    parameter int unsigned DEPTH      = 64,
    parameter int unsigned ITEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] entry_data,
    input  logic [5:0]  index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [6:0]  live_count,
    output logic [6:0]  pending_deletes,
    output logic [1:0]  status
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (CW > 7) ? CW : 7;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WMARK = 3'd3;
    localparam logic [2:0] S_WCHK  = 3'd4;
    localparam logic [2:0] S_WMOVE = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [XW-1:0] live_reg, live_next;
    logic [XW-1:0] queued_reg, queued_next;
    logic [6:0]  cap_reg;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_data_reg, out_data_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic [XW-1:0] cap_x, cap_u, idx_x, slot_x, live_m1;
    logic [12:0]   idx_w;
    logic [63:0]   in_wide, rd_wide;
    logic          accept, out_free;

    logic                  e_we, m_we, m_wdata;
    logic [AW-1:0]         e_waddr, e_raddr, m_waddr, m_raddr;
    logic [ITEM_WIDTH-1:0] e_wdata, e_rdata;
    logic                  m_rdata;

    dpdd_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(DEPTH)) u_entry_ram (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata)
    );

    dpdd_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark_ram (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );

    assign cap_x    = XW'(cap_reg);
    assign cap_u    = (cap_x > XW'(DEPTH)) ? XW'(DEPTH) : cap_x;
    assign idx_w    = 13'(index);
    assign idx_x    = XW'(index);
    assign slot_x   = XW'(slot_reg);
    assign live_m1  = live_reg - XW'(1);
    assign in_wide  = 64'(entry_data);
    assign rd_wide  = 64'(e_rdata);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        slot_next       = slot_reg;
        clr_next        = clr_reg;
        live_next       = live_reg;
        queued_next     = queued_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        e_we    = 1'b0;
        e_waddr = live_reg[AW-1:0];
        e_wdata = in_wide[ITEM_WIDTH-1:0];
        e_raddr = idx_w[AW-1:0];
        m_we    = 1'b0;
        m_waddr = idx_w[AW-1:0];
        m_wdata = 1'b1;
        m_raddr = slot_reg;
        case (state_reg)
            S_CLR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                m_wdata = 1'b0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    out_data_next   = '0;
                    out_status_next = dpdd_pkg::ST_OK;
                    case (operation)
                        dpdd_pkg::OP_ADD:
                        begin
                            out_valid_next = 1'b1;
                            if (live_reg < cap_u)
                            begin
                                e_we      = 1'b1;
                                live_next = live_reg + XW'(1);
                            end
                            else
                            begin
                                out_status_next = dpdd_pkg::ST_FULL;
                            end
                        end
                        dpdd_pkg::OP_DEL:
                        begin
                            out_valid_next = 1'b1;
                            if (idx_x >= cap_u)
                            begin
                                out_status_next = dpdd_pkg::ST_RANGE;
                            end
                            else if (queued_reg >= cap_u)
                            begin
                                out_status_next = dpdd_pkg::ST_QUEUEFULL;
                            end
                            else
                            begin
                                m_we        = 1'b1;
                                queued_next = queued_reg + XW'(1);
                            end
                        end
                        dpdd_pkg::OP_FLUSH:
                        begin
                            if (queued_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                slot_next  = AW'(DEPTH - 1);
                                state_next = S_WMARK;
                            end
                        end
                        default:
                        begin
                            if (idx_x < live_reg)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = dpdd_pkg::ST_RANGE;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_data_next  = rd_wide[31:0];
                state_next     = S_IDLE;
            end
            S_WMARK:
            begin
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                m_we    = 1'b1;
                m_waddr = slot_reg;
                m_wdata = 1'b0;
                e_raddr = live_m1[AW-1:0];
                if (m_rdata && (slot_x < live_reg) && (slot_x != live_m1))
                begin
                    state_next = S_WMOVE;
                end
                else
                begin
                    if (m_rdata && (slot_x < live_reg))
                    begin
                        live_next = live_m1;
                    end
                    if (slot_reg == '0)
                    begin
                        queued_next    = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg - AW'(1);
                        state_next = S_WMARK;
                    end
                end
            end
            S_WMOVE:
            begin
                e_we      = 1'b1;
                e_waddr   = slot_reg;
                e_wdata   = e_rdata;
                live_next = live_m1;
                if (slot_reg == '0)
                begin
                    queued_next    = '0;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    slot_next  = slot_reg - AW'(1);
                    state_next = S_WMARK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            slot_reg      <= '0;
            clr_reg       <= '0;
            live_reg      <= '0;
            queued_reg    <= '0;
            cap_reg       <= dpdd_pkg::CAP_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            queued_reg    <= queued_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_data_reg;
    assign status          = out_status_reg;
    assign live_count      = live_reg[6:0];
    assign pending_deletes = queued_reg[6:0];

`ifndef NO_ASSERTIONS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= XW'(DEPTH))
        else $error("live count above depth");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == dpdd_pkg::OP_ADD && live_reg < cap_u)
        |=> live_reg == $past(live_reg) + XW'(1))
        else $error("add did not grow pool");

    a_move_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WMOVE) |-> (live_reg != '0) && (slot_x < live_m1))
        else $error("move into slot outside live range");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_next == S_IDLE && state_reg != S_CLR
         && state_reg != S_READ) |=> queued_reg == '0)
        else $error("queue not cleared after flush");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for dense_pool_deferred_delete_unit.
// Drives a stimulus table, then weighted random operations, through both handshakes and
// checks results against a table row or predictor. Depends on dpdd_pkg and the pool RTL.
module tb_top;

    typedef struct packed {
        logic [31:0] read_data;
        logic [6:0]  live_count;
        logic [6:0]  pending_deletes;
        logic [1:0]  status;
    } pool_result_t;

    typedef struct {
        bit           is_cfg;
        logic [6:0]   cap;
        logic [1:0]   op;
        logic [31:0]  data;
        logic [5:0]   idx;
        bit           typed;
        pool_result_t res;
    } pool_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = dpdd_pkg::OP_ADD;
    logic [31:0] entry_data = '0;
    logic [5:0]  index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;
    logic [6:0]  live_count;
    logic [6:0]  pending_deletes;
    logic [1:0]  status;

    bit           row_typed = 1'b0;
    pool_result_t row_res = '0;

    logic [31:0]  pool_mem [64];
    int unsigned  pool_live;
    logic [5:0]   del_list [64];
    int unsigned  del_count;
    int unsigned  pool_cap;

    pool_result_t result_q [$];
    int unsigned  mismatches;
    bit           gaps_on;
    bit           hold_req;

    dense_pool_deferred_delete_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .entry_data      (entry_data),
        .index           (index),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .live_count      (live_count),
        .pending_deletes (pending_deletes),
        .status          (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void flush_pool();
        int unsigned n;
        logic [5:0]  v;
        int          j;
        bit          have_prev;
        logic [5:0]  prev;
        n = del_count;
        have_prev = 1'b0;
        prev = '0;
        for (int i = 1; i < n; i++)
        begin
            v = del_list[i];
            j = i;
            while (j > 0 && del_list[j-1] > v)
            begin
                del_list[j] = del_list[j-1];
                j--;
            end
            del_list[j] = v;
        end
        for (int i = n; i > 0; i--)
        begin
            v = del_list[i-1];
            if (!(have_prev && v == prev))
            begin
                have_prev = 1'b1;
                prev = v;
                if (v < pool_live)
                begin
                    pool_mem[v] = pool_mem[pool_live-1];
                    pool_live--;
                end
            end
        end
        del_count = 0;
    endfunction

    function automatic pool_result_t apply_item(logic [1:0] op, logic [31:0] d,
                                                logic [5:0] idx);
        pool_result_t r;
        int unsigned  cap;
        cap = (pool_cap > 64) ? 64 : pool_cap;
        r = '0;
        r.status = dpdd_pkg::ST_OK;
        case (op)
            dpdd_pkg::OP_ADD:
                if (pool_live < cap)
                begin
                    pool_mem[pool_live] = d;
                    pool_live++;
                end
                else
                    r.status = dpdd_pkg::ST_FULL;
            dpdd_pkg::OP_DEL:
                if (idx >= cap)
                    r.status = dpdd_pkg::ST_RANGE;
                else if (del_count >= cap)
                    r.status = dpdd_pkg::ST_QUEUEFULL;
                else
                begin
                    del_list[del_count] = idx;
                    del_count++;
                end
            dpdd_pkg::OP_FLUSH:
                flush_pool();
            default:
                if (idx < pool_live)
                    r.read_data = pool_mem[idx];
                else
                    r.status = dpdd_pkg::ST_RANGE;
        endcase
        r.live_count = pool_live[6:0];
        r.pending_deletes = del_count[6:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        pool_result_t p;
        pool_result_t got;
        pool_result_t want;
        if (in_valid && in_ready)
        begin
            p = apply_item(operation, entry_data, index);
            result_q.push_back(row_typed ? row_res : p);
        end
        if (out_valid && out_ready)
        begin
            got = {read_data, live_count, pending_deletes, status};
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %h %0d %0d %0d", read_data, live_count,
                             pending_deletes, status);
            end
            else
            begin
                want = result_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %0d %0d %0d got %h %0d %0d %0d",
                                 want.read_data, want.live_count, want.pending_deletes,
                                 want.status, read_data, live_count, pending_deletes,
                                 status);
                end
            end
        end
    end

    always
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            out_ready <= 1'b0;
            repeat (300) @(posedge clk);
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        else
        begin
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(logic [1:0] op, logic [31:0] d, logic [5:0] idx, bit typed,
                             pool_result_t res);
        if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        entry_data <= d;
        index      <= idx;
        row_typed  <= typed;
        row_res    <= res;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic write_capacity(logic [6:0] cap);
        in_valid <= 1'b0;
        @(posedge clk);
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pool_cap = 32'(cap);
    endtask

    function automatic pool_row_t mk(logic [1:0] op, logic [31:0] d, logic [5:0] idx,
                                     bit typed, logic [31:0] rd, int lc, int pd,
                                     logic [1:0] st);
        pool_row_t r;
        r.is_cfg = 1'b0;
        r.cap = '0;
        r.op = op;
        r.data = d;
        r.idx = idx;
        r.typed = typed;
        r.res = {rd, lc[6:0], pd[6:0], st};
        return r;
    endfunction

    function automatic pool_row_t mk_cfg(logic [6:0] cap);
        pool_row_t r;
        r = mk(dpdd_pkg::OP_FLUSH, '0, '0, 1'b0, '0, 0, 0, dpdd_pkg::ST_OK);
        r.is_cfg = 1'b1;
        r.cap = cap;
        return r;
    endfunction

    task automatic run_random(int unsigned count);
        int unsigned sel;
        logic [1:0]  op;
        logic [5:0]  idx;
        for (int unsigned k = 0; k < count; k++)
        begin
            sel = $urandom_range(0, 99);
            op = (sel < 35) ? dpdd_pkg::OP_ADD : (sel < 65) ? dpdd_pkg::OP_DEL :
                 (sel < 90) ? dpdd_pkg::OP_READ : dpdd_pkg::OP_FLUSH;
            if ($urandom_range(0, 4) == 0 || pool_live == 0)
                idx = 6'($urandom_range(0, 63));
            else
                idx = 6'($urandom_range(0, pool_live - 1));
            send_item(op, $urandom, idx, 1'b0, '0);
        end
    endtask

    pool_row_t   rows [$];
    logic [6:0]  caps [10] = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd2, 7'd20, 7'd64, 7'd5,
                               7'd33, 7'd64};

    initial
    begin
        mismatches = 0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        pool_live = 0;
        del_count = 0;
        pool_cap = 64;
        for (int i = 0; i < 64; i++)
        begin
            pool_mem[i] = '0;
            del_list[i] = '0;
        end
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd0,  1'b1, '0,
                          0, 0, dpdd_pkg::ST_RANGE));
        rows.push_back(mk(dpdd_pkg::OP_FLUSH, '0,           6'd0,  1'b1, '0,
                          0, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_ADD,   32'hFFFFFFFF, 6'd0,  1'b1, '0,
                          1, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_ADD,   32'h0,        6'd63, 1'b1, '0,
                          2, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_ADD,   32'hA5A55A5A, 6'd0,  1'b1, '0,
                          3, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd0,  1'b1, 32'hFFFFFFFF,
                          3, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd2,  1'b1, 32'hA5A55A5A,
                          3, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd3,  1'b1, '0,
                          3, 0, dpdd_pkg::ST_RANGE));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd63, 1'b1, '0,
                          3, 1, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd0,  1'b1, '0,
                          3, 2, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd0,  1'b1, '0,
                          3, 3, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd1,  1'b1, '0,
                          3, 4, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_FLUSH, '0,           6'd0,  1'b0, '0,
                          0, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd0,  1'b0, '0,
                          0, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd63, 1'b0, '0,
                          0, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk_cfg(7'd1));
        rows.push_back(mk(dpdd_pkg::OP_ADD,   32'h12345678, 6'd0,  1'b1, '0,
                          1, 0, dpdd_pkg::ST_FULL));
        rows.push_back(mk(dpdd_pkg::OP_READ,  '0,           6'd0,  1'b0, '0,
                          0, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd1,  1'b1, '0,
                          1, 0, dpdd_pkg::ST_RANGE));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd0,  1'b1, '0,
                          1, 1, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_DEL,   '0,           6'd0,  1'b1, '0,
                          1, 1, dpdd_pkg::ST_QUEUEFULL));
        rows.push_back(mk(dpdd_pkg::OP_FLUSH, '0,           6'd0,  1'b1, '0,
                          0, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_ADD,   32'h80000001, 6'd0,  1'b1, '0,
                          1, 0, dpdd_pkg::ST_OK));
        rows.push_back(mk(dpdd_pkg::OP_ADD,   32'h7FFFFFFE, 6'd0,  1'b1, '0,
                          1, 0, dpdd_pkg::ST_FULL));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[r])
        begin
            if (rows[r].is_cfg)
                write_capacity(rows[r].cap);
            else
                send_item(rows[r].op, rows[r].data, rows[r].idx, rows[r].typed,
                          rows[r].res);
        end

        foreach (caps[c])
        begin
            write_capacity(caps[c]);
            if (c == 9)
                gaps_on = 1'b0;
            if (c == 6)
            begin
                run_random(40);
                hold_req = 1'b1;
                run_random(160);
            end
            else
                run_random(190);
        end

        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(12 * 3000000);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ sim.f @@
src/dpdd_pkg.sv
src/dpdd_ram.sv
src/dense_pool_deferred_delete_unit.sv
verif/tb_top.sv
